// ===== rtl/i2c_mte_pkg.sv =====
package i2c_mte_pkg;

   localparam int BUFFER_DEPTH_DEFAULT = 256;
   localparam logic [15:0] HALF_PERIOD_RESET = 16'd20;

   typedef enum logic [1:0] {
      CMD_TICK  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_READ  = 2'd2,
      CMD_LOAD  = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      STATUS_OK   = 2'd0,
      STATUS_LOST = 2'd1,
      STATUS_NACK = 2'd2
   } status_type;

endpackage

// ===== rtl/i2c_master_transaction_engine.sv =====
// The result of a transaction is registered and presented in the cycle after it is accepted.
// Throughput: one transaction per cycle; only the result register's handshake
// with the downstream side sets the pace.
// Reset is synchronous and active high; it clears the sequencer, counters and the
// half period register (to 20), but not the write buffer, which holds garbage until loaded.
module i2c_master_transaction_engine #(
   parameter int BUFFER_DEPTH = i2c_mte_pkg::BUFFER_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [15:0]              csr_data,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  i2c_mte_pkg::command_type req_command,
   input  logic [6:0]               req_device_address,
   input  logic [7:0]               req_byte_count,
   input  logic [7:0]               req_byte_index,
   input  logic [7:0]               req_write_byte,
   input  logic                     req_sda_sample,
   input  logic                     req_scl_sample,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_scl_drive,
   output logic                     rsp_sda_drive,
   output logic [7:0]               rsp_read_data,
   output logic                     rsp_read_valid,
   output logic                     rsp_busy_res,
   output logic                     rsp_done_res,
   output i2c_mte_pkg::status_type  rsp_status
);

   import i2c_mte_pkg::*;

   localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

   typedef enum logic [4:0] {
      PH_IDLE      = 5'd0,
      PH_START     = 5'd1,
      PH_TX_LOW    = 5'd2,
      PH_TX_HIGH   = 5'd3,
      PH_ACK_LOW   = 5'd4,
      PH_ACK_HIGH  = 5'd5,
      PH_RX_LOW    = 5'd6,
      PH_RX_HIGH   = 5'd7,
      PH_MACK_LOW  = 5'd8,
      PH_MACK_HIGH = 5'd9,
      PH_STOP_LOW  = 5'd10,
      PH_STOP_HIGH = 5'd11
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [15:0] hp_ff;
   logic [15:0] tick_ff, tick_in;
   logic [3:0]  bit_ff, bit_in;
   logic [8:0]  left_ff, left_in;
   logic [7:0]  shift_ff, shift_in;
   logic        is_read_ff, is_read_in;
   status_type  status_ff, status_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic        scl_ff, scl_in;
   logic        sda_ff, sda_in;

   logic        rsp_valid_ff;
   logic        rsp_scl_ff, rsp_sda_ff, rsp_read_valid_ff, rsp_busy_ff, rsp_done_ff;
   logic [7:0]  rsp_read_data_ff;
   status_type  rsp_status_ff;

   logic        req_fire;
   logic        high_phase;
   logic        in_range;
   logic        ram_we;
   logic [7:0]  ram_rd_data;
   logic [15:0] hp;
   logic [15:0] tick_inc;
   logic [8:0]  left_dec;
   logic [3:0]  bit_dec;
   logic [2:0]  tx_bit;
   logic [7:0]  rx_shift;
   logic [AW-1:0] ptr_next;
   status_type  st;
   logic        rd_valid;
   logic [7:0]  rd_byte;
   logic        done;

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   assign in_range = {1'b0, req_byte_index} < 9'(BUFFER_DEPTH);
   assign ptr_next = (ptr_ff == AW'(BUFFER_DEPTH - 1)) ? '0 : ptr_ff + 1'b1;

   // The read port follows the buffer pointer all the time; the pointer moves only
   // at the end of an ACK phase, long before the next byte is fetched.
   i2c_mte_ram #(
      .WIDTH (8),
      .DEPTH (BUFFER_DEPTH),
      .AW    (AW)
   ) u_buffer (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (req_byte_index[AW-1:0]),
      .wr_data (req_write_byte),
      .rd_addr (ptr_ff),
      .rd_data (ram_rd_data)
   );

   assign high_phase = phase_ff == PH_TX_HIGH || phase_ff == PH_ACK_HIGH ||
                       phase_ff == PH_RX_HIGH || phase_ff == PH_MACK_HIGH ||
                       phase_ff == PH_STOP_HIGH;

   always_comb begin
      phase_in   = phase_ff;
      tick_in    = tick_ff;
      bit_in     = bit_ff;
      left_in    = left_ff;
      shift_in   = shift_ff;
      is_read_in = is_read_ff;
      status_in  = status_ff;
      ptr_in     = ptr_ff;
      scl_in     = scl_ff;
      sda_in     = sda_ff;
      ram_we     = 1'b0;
      rd_valid   = 1'b0;
      rd_byte    = 8'd0;
      done       = 1'b0;
      hp         = (hp_ff == 16'd0) ? 16'd1 : hp_ff;
      tick_inc   = tick_ff + 16'd1;
      left_dec   = left_ff - 9'd1;
      bit_dec    = bit_ff - 4'd1;
      tx_bit     = bit_dec[2:0];
      rx_shift   = {shift_ff[6:0], req_sda_sample};
      st         = status_ff;

      if (phase_ff == PH_IDLE) begin
         scl_in = 1'b1;
         sda_in = 1'b1;
         unique case (req_command)
            CMD_LOAD: begin
               ram_we = req_fire && in_range;
            end
            CMD_WRITE, CMD_READ: begin
               if (req_scl_sample && req_sda_sample) begin
                  is_read_in = req_command == CMD_READ;
                  shift_in   = {req_device_address, req_command == CMD_READ};
                  left_in    = (req_command == CMD_READ) ? {1'b0, req_byte_count}
                                                         : {1'b0, req_byte_count} + 9'd1;
                  ptr_in     = '0;
                  status_in  = STATUS_OK;
                  tick_in    = 16'd0;
                  bit_in     = 4'd0;
                  phase_in   = PH_START;
                  sda_in     = 1'b0;
               end else begin
                  status_in = STATUS_LOST;
                  done      = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end else if (!(high_phase && !req_scl_sample)) begin
         // A stretched SCL holds the high phases without counting.
         tick_in = tick_inc;
         if (tick_inc >= hp) begin
            tick_in = 16'd0;
            unique case (phase_ff)
               PH_START: begin
                  phase_in = PH_TX_LOW;
                  scl_in   = 1'b0;
                  bit_in   = 4'd7;
                  sda_in   = shift_ff[7];
               end
               PH_TX_LOW: begin
                  phase_in = PH_TX_HIGH;
                  scl_in   = 1'b1;
               end
               PH_ACK_LOW: begin
                  phase_in = PH_ACK_HIGH;
                  scl_in   = 1'b1;
               end
               PH_RX_LOW: begin
                  phase_in = PH_RX_HIGH;
                  scl_in   = 1'b1;
               end
               PH_MACK_LOW: begin
                  phase_in = PH_MACK_HIGH;
                  scl_in   = 1'b1;
               end
               PH_STOP_LOW: begin
                  phase_in = PH_STOP_HIGH;
                  scl_in   = 1'b1;
               end
               PH_TX_HIGH: begin
                  if (req_sda_sample != sda_ff) begin
                     st = STATUS_LOST;
                  end
                  status_in = st;
                  if (bit_ff != 4'd0 && st == STATUS_OK) begin
                     phase_in = PH_TX_LOW;
                     scl_in   = 1'b0;
                     bit_in   = {1'b0, tx_bit};
                     sda_in   = shift_ff[tx_bit];
                  end else begin
                     phase_in = PH_ACK_LOW;
                     scl_in   = 1'b0;
                     sda_in   = 1'b1;
                  end
               end
               PH_ACK_HIGH: begin
                  if (req_sda_sample) begin
                     st = STATUS_NACK;
                  end
                  status_in = st;
                  if (!is_read_ff) begin
                     left_in  = left_dec;
                     shift_in = ram_rd_data;
                     ptr_in   = ptr_next;
                     if (left_dec != 9'd0 && st == STATUS_OK) begin
                        phase_in = PH_TX_LOW;
                        scl_in   = 1'b0;
                        bit_in   = 4'd7;
                        sda_in   = ram_rd_data[7];
                     end else begin
                        phase_in = PH_STOP_LOW;
                        scl_in   = 1'b0;
                        sda_in   = 1'b0;
                     end
                  end else if (left_ff != 9'd0 && st == STATUS_OK) begin
                     bit_in   = 4'd8;
                     phase_in = PH_RX_LOW;
                     scl_in   = 1'b0;
                     sda_in   = 1'b1;
                  end else begin
                     phase_in = PH_STOP_LOW;
                     scl_in   = 1'b0;
                     sda_in   = 1'b0;
                  end
               end
               PH_RX_HIGH: begin
                  shift_in = rx_shift;
                  bit_in   = bit_dec;
                  if (bit_dec != 4'd0) begin
                     phase_in = PH_RX_LOW;
                     scl_in   = 1'b0;
                     sda_in   = 1'b1;
                  end else begin
                     rd_valid = 1'b1;
                     rd_byte  = rx_shift;
                     phase_in = PH_MACK_LOW;
                     scl_in   = 1'b0;
                     // The last byte of a read is answered with NACK.
                     sda_in   = left_ff == 9'd1;
                  end
               end
               PH_MACK_HIGH: begin
                  left_in = left_dec;
                  if (left_dec != 9'd0) begin
                     bit_in   = 4'd8;
                     phase_in = PH_RX_LOW;
                     scl_in   = 1'b0;
                     sda_in   = 1'b1;
                  end else begin
                     phase_in = PH_STOP_LOW;
                     scl_in   = 1'b0;
                     sda_in   = 1'b0;
                  end
               end
               PH_STOP_HIGH: begin
                  sda_in   = 1'b1;
                  phase_in = PH_IDLE;
                  done     = 1'b1;
               end
               default: begin
                  phase_in = PH_IDLE;
                  scl_in   = 1'b1;
                  sda_in   = 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_IDLE;
         hp_ff             <= HALF_PERIOD_RESET;
         tick_ff           <= 16'd0;
         bit_ff            <= 4'd0;
         left_ff           <= 9'd0;
         shift_ff          <= 8'd0;
         is_read_ff        <= 1'b0;
         status_ff         <= STATUS_OK;
         ptr_ff            <= '0;
         scl_ff            <= 1'b1;
         sda_ff            <= 1'b1;
         rsp_valid_ff      <= 1'b0;
         rsp_scl_ff        <= 1'b1;
         rsp_sda_ff        <= 1'b1;
         rsp_read_data_ff  <= 8'd0;
         rsp_read_valid_ff <= 1'b0;
         rsp_busy_ff       <= 1'b0;
         rsp_done_ff       <= 1'b0;
         rsp_status_ff     <= STATUS_OK;
      end else begin
         if (csr_valid) begin
            hp_ff <= csr_data;
         end
         if (req_fire) begin
            phase_ff          <= phase_in;
            tick_ff           <= tick_in;
            bit_ff            <= bit_in;
            left_ff           <= left_in;
            shift_ff          <= shift_in;
            is_read_ff        <= is_read_in;
            status_ff         <= status_in;
            ptr_ff            <= ptr_in;
            scl_ff            <= scl_in;
            sda_ff            <= sda_in;
            rsp_valid_ff      <= 1'b1;
            rsp_scl_ff        <= scl_in;
            rsp_sda_ff        <= sda_in;
            rsp_read_data_ff  <= rd_byte;
            rsp_read_valid_ff <= rd_valid;
            rsp_busy_ff       <= phase_in != PH_IDLE;
            rsp_done_ff       <= done;
            rsp_status_ff     <= status_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_scl_drive  = rsp_scl_ff;
   assign rsp_sda_drive  = rsp_sda_ff;
   assign rsp_read_data  = rsp_read_data_ff;
   assign rsp_read_valid = rsp_read_valid_ff;
   assign rsp_busy_res   = rsp_busy_ff;
   assign rsp_done_res   = rsp_done_ff;
   assign rsp_status     = rsp_status_ff;

   a_begin_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire && phase_ff == PH_IDLE && req_sda_sample && req_scl_sample &&
      (req_command == CMD_WRITE || req_command == CMD_READ)
      |=> rsp_valid && rsp_busy_res && phase_ff == PH_START)
      else $error("begin on a free bus did not start a transaction");

   a_read_byte_phase: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_read_valid |-> is_read_ff && phase_ff == PH_MACK_LOW)
      else $error("read byte reported outside a read acknowledge phase");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> phase_ff == PH_IDLE && !rsp_busy_res)
      else $error("transaction done while the sequencer is still busy");

endmodule

// ===== rtl/i2c_mte_ram.sv =====
module i2c_mte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== dv/i2c_master_transaction_engine_tb.sv =====
`timescale 1ns / 100ps

module i2c_master_transaction_engine_tb;
   import i2c_mte_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 8;
   localparam int STRETCH_PCT   = 15;

   typedef enum int {
      BUS_IDLE,
      BUS_START,
      BUS_TX_LOW,
      BUS_TX_HIGH,
      BUS_ACK_LOW,
      BUS_ACK_HIGH,
      BUS_RX_LOW,
      BUS_RX_HIGH,
      BUS_MACK_LOW,
      BUS_MACK_HIGH,
      BUS_STOP_LOW,
      BUS_STOP_HIGH
   } bus_phase_type;

   typedef struct {
      command_type command;
      logic [6:0]  device_address;
      logic [7:0]  byte_count;
      logic [7:0]  byte_index;
      logic [7:0]  write_byte;
      logic        sda_sample;
      logic        scl_sample;
   } i2c_tick_type;

   typedef struct {
      logic       scl_drive;
      logic       sda_drive;
      logic [7:0] read_data;
      logic       read_valid;
      logic       busy;
      logic       done;
      status_type status;
   } bus_drive_type;

   class i2c_tick_scoreboard;
      logic [15:0]   half_period;
      bus_phase_type phase;
      logic [15:0]   tick_count;
      logic [3:0]    bit_count;
      logic [8:0]    bytes_left;
      logic [7:0]    shift_reg;
      logic          reading;
      status_type    last_status;
      logic [7:0]    buffer_pointer;
      logic [7:0]    write_buffer [256];
      bit            loaded [256];
      logic          scl_level;
      logic          sda_level;
      bus_drive_type next_drive;
      bus_drive_type expected_drive_q [$];
      int            error_count;
      int            response_count;

      function new();
         half_period    = HALF_PERIOD_RESET;
         phase          = BUS_IDLE;
         tick_count     = '0;
         bit_count      = '0;
         bytes_left     = '0;
         shift_reg      = '0;
         reading        = 1'b0;
         last_status    = STATUS_OK;
         buffer_pointer = '0;
         scl_level      = 1'b1;
         sda_level      = 1'b1;
         error_count    = 0;
         response_count = 0;
         for (int i = 0; i < 256; i++) begin
            write_buffer[i] = '0;
            loaded[i]       = 1'b0;
         end
      endfunction

      function bit in_high_phase();
         return phase == BUS_TX_HIGH || phase == BUS_ACK_HIGH || phase == BUS_RX_HIGH ||
                phase == BUS_MACK_HIGH || phase == BUS_STOP_HIGH;
      endfunction

      function void start_tx_bit();
         phase     = BUS_TX_LOW;
         scl_level = 1'b0;
         bit_count = (bit_count - 4'd1) & 4'd7;
         sda_level = shift_reg[bit_count[2:0]];
      endfunction

      function void start_rx_bit();
         phase     = BUS_RX_LOW;
         scl_level = 1'b0;
         sda_level = 1'b1;
      endfunction

      function void start_stop();
         phase     = BUS_STOP_LOW;
         scl_level = 1'b0;
         sda_level = 1'b0;
      endfunction

      function void end_half_period(logic sda);
         case (phase)
            BUS_START: begin
               bit_count = 4'd8;
               start_tx_bit();
            end
            BUS_TX_LOW: begin
               phase     = BUS_TX_HIGH;
               scl_level = 1'b1;
            end
            BUS_ACK_LOW: begin
               phase     = BUS_ACK_HIGH;
               scl_level = 1'b1;
            end
            BUS_RX_LOW: begin
               phase     = BUS_RX_HIGH;
               scl_level = 1'b1;
            end
            BUS_MACK_LOW: begin
               phase     = BUS_MACK_HIGH;
               scl_level = 1'b1;
            end
            BUS_STOP_LOW: begin
               phase     = BUS_STOP_HIGH;
               scl_level = 1'b1;
            end
            BUS_TX_HIGH: begin
               // Another master pulled SDA away from the driven bit.
               if (sda != sda_level)
                  last_status = STATUS_LOST;
               if (bit_count != 4'd0 && last_status == STATUS_OK) begin
                  start_tx_bit();
               end else begin
                  phase     = BUS_ACK_LOW;
                  scl_level = 1'b0;
                  sda_level = 1'b1;
               end
            end
            BUS_ACK_HIGH: begin
               if (sda)
                  last_status = STATUS_NACK;
               if (!reading) begin
                  bytes_left     = bytes_left - 9'd1;
                  shift_reg      = write_buffer[buffer_pointer];
                  buffer_pointer = buffer_pointer + 8'd1;
                  if (bytes_left != 9'd0 && last_status == STATUS_OK) begin
                     bit_count = 4'd8;
                     start_tx_bit();
                  end else begin
                     start_stop();
                  end
               end else if (bytes_left != 9'd0 && last_status == STATUS_OK) begin
                  bit_count = 4'd8;
                  start_rx_bit();
               end else begin
                  start_stop();
               end
            end
            BUS_RX_HIGH: begin
               shift_reg = {shift_reg[6:0], sda};
               bit_count = bit_count - 4'd1;
               if (bit_count != 4'd0) begin
                  start_rx_bit();
               end else begin
                  next_drive.read_data  = shift_reg;
                  next_drive.read_valid = 1'b1;
                  phase     = BUS_MACK_LOW;
                  scl_level = 1'b0;
                  // The last byte of a read is answered with NACK.
                  sda_level = (bytes_left == 9'd1);
               end
            end
            BUS_MACK_HIGH: begin
               bytes_left = bytes_left - 9'd1;
               if (bytes_left != 9'd0) begin
                  bit_count = 4'd8;
                  start_rx_bit();
               end else begin
                  start_stop();
               end
            end
            BUS_STOP_HIGH: begin
               sda_level       = 1'b1;
               phase           = BUS_IDLE;
               next_drive.done = 1'b1;
            end
            default: begin
               phase     = BUS_IDLE;
               scl_level = 1'b1;
               sda_level = 1'b1;
            end
         endcase
      endfunction

      function void note_tick(i2c_tick_type t);
         logic [15:0] span;
         span = (half_period == 16'd0) ? 16'd1 : half_period;
         next_drive.read_data  = 8'h00;
         next_drive.read_valid = 1'b0;
         next_drive.done       = 1'b0;
         if (phase == BUS_IDLE) begin
            scl_level = 1'b1;
            sda_level = 1'b1;
            if (t.command == CMD_LOAD) begin
               write_buffer[t.byte_index] = t.write_byte;
               loaded[t.byte_index]       = 1'b1;
            end else if (t.command == CMD_WRITE || t.command == CMD_READ) begin
               if (t.scl_sample && t.sda_sample) begin
                  reading        = (t.command == CMD_READ);
                  shift_reg      = {t.device_address, reading};
                  bytes_left     = reading ? {1'b0, t.byte_count} : {1'b0, t.byte_count} + 9'd1;
                  buffer_pointer = '0;
                  last_status    = STATUS_OK;
                  tick_count     = '0;
                  bit_count      = '0;
                  phase          = BUS_START;
                  sda_level      = 1'b0;
               end else begin
                  last_status     = STATUS_LOST;
                  next_drive.done = 1'b1;
               end
            end
         end else if (!(in_high_phase() && !t.scl_sample)) begin
            // A stretched SCL freezes the high phase counter.
            tick_count = tick_count + 16'd1;
            if (tick_count >= span) begin
               tick_count = '0;
               end_half_period(t.sda_sample);
            end
         end
         next_drive.scl_drive = scl_level;
         next_drive.sda_drive = sda_level;
         next_drive.busy      = (phase != BUS_IDLE);
         next_drive.status    = last_status;
         expected_drive_q.push_back(next_drive);
      endfunction

      task report_mismatch(string what);
         error_count++;
         if (error_count <= 100)
            $display("ERROR: response %0d: %s", response_count, what);
      endtask

      task compare_field(string name, logic [7:0] got, logic [7:0] want);
         if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
      endtask

      task check_drive(bus_drive_type got);
         bus_drive_type want;
         response_count++;
         if (expected_drive_q.size() == 0) begin
            report_mismatch("response arrived with no transaction outstanding");
            return;
         end
         want = expected_drive_q.pop_front();
         compare_field("scl_drive", 8'(got.scl_drive), 8'(want.scl_drive));
         compare_field("sda_drive", 8'(got.sda_drive), 8'(want.sda_drive));
         compare_field("read_data", got.read_data, want.read_data);
         compare_field("read_valid", 8'(got.read_valid), 8'(want.read_valid));
         compare_field("busy_res", 8'(got.busy), 8'(want.busy));
         compare_field("done_res", 8'(got.done), 8'(want.done));
         compare_field("status", 8'(got.status), 8'(want.status));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   command_type req_command = CMD_TICK;
   logic [6:0]  req_device_address = '0;
   logic [7:0]  req_byte_count = '0;
   logic [7:0]  req_byte_index = '0;
   logic [7:0]  req_write_byte = '0;
   logic        req_sda_sample = 1'b1;
   logic        req_scl_sample = 1'b1;
   logic        rsp_valid;
   logic        rsp_ready = 1'b1;
   logic        rsp_scl_drive;
   logic        rsp_sda_drive;
   logic [7:0]  rsp_read_data;
   logic        rsp_read_valid;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   status_type  rsp_status;

   i2c_tick_scoreboard sb;
   int          sender_idle_pct = 0;
   int          receiver_stall_pct = 0;
   int          ticks_sent = 0;
   int unsigned cycle_count = 0;

   i2c_master_transaction_engine dut (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_data           (csr_data),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_command        (req_command),
      .req_device_address (req_device_address),
      .req_byte_count     (req_byte_count),
      .req_byte_index     (req_byte_index),
      .req_write_byte     (req_write_byte),
      .req_sda_sample     (req_sda_sample),
      .req_scl_sample     (req_scl_sample),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_scl_drive      (rsp_scl_drive),
      .rsp_sda_drive      (rsp_sda_drive),
      .rsp_read_data      (rsp_read_data),
      .rsp_read_valid     (rsp_read_valid),
      .rsp_busy_res       (rsp_busy_res),
      .rsp_done_res       (rsp_done_res),
      .rsp_status         (rsp_status)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin : rsp_monitor
      bus_drive_type got;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got.scl_drive  = rsp_scl_drive;
            got.sda_drive  = rsp_sda_drive;
            got.read_data  = rsp_read_data;
            got.read_valid = rsp_read_valid;
            got.busy       = rsp_busy_res;
            got.done       = rsp_done_res;
            got.status     = rsp_status;
            sb.check_drive(got);
         end
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   function automatic i2c_tick_type random_tick();
      i2c_tick_type t;
      t.command        = command_type'($urandom_range(3));
      t.device_address = 7'($urandom_range(127));
      t.byte_count     = 8'($urandom_range(255));
      t.byte_index     = 8'($urandom_range(255));
      t.write_byte     = 8'($urandom_range(255));
      t.sda_sample     = 1'($urandom_range(1));
      t.scl_sample     = 1'($urandom_range(1));
      return t;
   endfunction

   // Plays the target and the bus while a transfer is running.
   function automatic i2c_tick_type bus_tick(int lose_pct, int nack_pct);
      i2c_tick_type t;
      t = random_tick();
      t.command    = ($urandom_range(9) == 0) ? command_type'($urandom_range(3)) : CMD_TICK;
      t.scl_sample = 1'b1;
      case (sb.phase)
         BUS_TX_HIGH:  t.sda_sample = ($urandom_range(99) < lose_pct) ? !sb.sda_level
                                                                       : sb.sda_level;
         BUS_ACK_HIGH: t.sda_sample = ($urandom_range(99) < nack_pct);
         default: ;
      endcase
      if (sb.in_high_phase() && $urandom_range(99) < STRETCH_PCT)
         t.scl_sample = 1'b0;
      return t;
   endfunction

   task automatic drive_tick(i2c_tick_type t);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_command        <= t.command;
      req_device_address <= t.device_address;
      req_byte_count     <= t.byte_count;
      req_byte_index     <= t.byte_index;
      req_write_byte     <= t.write_byte;
      req_sda_sample     <= t.sda_sample;
      req_scl_sample     <= t.scl_sample;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      sb.note_tick(t);
      ticks_sent++;
   endtask

   task automatic release_request();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_half_period(logic [15:0] value);
      release_request();
      while (sb.expected_drive_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      sb.half_period = value;
   endtask

   task automatic run_transfer(command_type op, logic [6:0] addr, logic [7:0] count,
                               int lose_pct, int nack_pct);
      i2c_tick_type t;
      int i;
      // A write fetches entries up to and including byte_count, so all must hold data.
      if (op == CMD_WRITE) begin
         for (i = 0; i <= count; i++) begin
            if (!sb.loaded[i] || $urandom_range(7) == 0) begin
               t = random_tick();
               t.command    = CMD_LOAD;
               t.byte_index = i[7:0];
               drive_tick(t);
            end
         end
      end
      t = random_tick();
      t.command        = op;
      t.device_address = addr;
      t.byte_count     = count;
      t.sda_sample     = 1'b1;
      t.scl_sample     = 1'b1;
      drive_tick(t);
      while (sb.phase != BUS_IDLE)
         drive_tick(bus_tick(lose_pct, nack_pct));
   endtask

   // Idle traffic only: a begin always sees a busy bus here.
   task automatic send_idle_noise(int count);
      i2c_tick_type t;
      repeat (count) begin
         t = random_tick();
         if ((t.command == CMD_WRITE || t.command == CMD_READ) &&
             t.sda_sample && t.scl_sample) begin
            if ($urandom_range(1))
               t.sda_sample = 1'b0;
            else
               t.scl_sample = 1'b0;
         end
         drive_tick(t);
      end
   endtask

   initial begin
      i2c_tick_type t;
      logic [15:0]  hp_plan [8];
      int           ph;
      int           phase_start;
      bit           faulty;

      sb = new();
      hp_plan = '{16'd2, 16'd0, 16'd3, 16'd65535, 16'd1, 16'd4, 16'd1, 16'd2};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      t = '{CMD_TICK, 7'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0};
      drive_tick(t);
      t = '{CMD_TICK, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1};
      drive_tick(t);
      t = '{CMD_LOAD, 7'h7F, 8'hFF, 8'h00, 8'h00, 1'b1, 1'b1};
      drive_tick(t);
      t = '{CMD_LOAD, 7'h00, 8'h00, 8'hFF, 8'hFF, 1'b0, 1'b0};
      drive_tick(t);
      t = '{CMD_WRITE, 7'h7F, 8'h01, 8'h00, 8'h00, 1'b0, 1'b1};
      drive_tick(t);
      t = '{CMD_READ, 7'h00, 8'h01, 8'h00, 8'h00, 1'b1, 1'b0};
      drive_tick(t);
      t = '{CMD_WRITE, 7'h2A, 8'h03, 8'h00, 8'h00, 1'b0, 1'b0};
      drive_tick(t);
      // One short transfer at the reset half period, cut off by lost arbitration.
      run_transfer(CMD_WRITE, 7'h00, 8'd0, 100, 0);

      write_half_period(16'd1);
      run_transfer(CMD_READ, 7'h7F, 8'd2, 0, 0);
      run_transfer(CMD_READ, 7'h2A, 8'd0, 0, 0);
      // Arbitration is lost on the first address bit and the ACK slot sees a NACK.
      run_transfer(CMD_WRITE, 7'h55, 8'd1, 100, 100);
      run_transfer(CMD_WRITE, 7'h33, 8'd2, 0, 100);

      for (ph = 0; ph < 8; ph++) begin
         write_half_period(hp_plan[ph]);
         case (ph % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 70; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 70; end
            default: begin sender_idle_pct = 18; receiver_stall_pct = 18; end
         endcase
         phase_start = ticks_sent;
         while (ticks_sent - phase_start < 30) begin
            // Longer half periods get idle traffic only, which keeps the run short.
            if (hp_plan[ph] > 16'd2 || $urandom_range(4) == 0) begin
               send_idle_noise($urandom_range(1, 4));
            end else begin
               faulty = ($urandom_range(3) == 0);
               run_transfer($urandom_range(1) ? CMD_READ : CMD_WRITE,
                            7'($urandom_range(127)),
                            ($urandom_range(9) == 0) ? 8'($urandom_range(2, 4))
                                                     : 8'($urandom_range(0, 1)),
                            faulty ? 3 : 0, faulty ? 5 : 0);
            end
         end
      end

      release_request();
      while (sb.expected_drive_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
